FILE: hw/rtl/prhst_pkg.sv
// Shared types and constants for the RAW hazard stall tracker.
package prhst_pkg;

  // Pipeline geometry
  localparam int NUM_STAGES       = 8;
  localparam int DECODE_STAGE     = 2;
  localparam int FIRST_EXEC_STAGE = 3;

  // Field widths
  localparam int REG_W  = 5;
  localparam int SEL_W  = 3;
  localparam int CTR_W  = 32;
  localparam int CNT_W  = 4;
  localparam int BUB_W  = 3;

  localparam logic [CTR_W-1:0] CYCLE_RESET = CTR_W'(NUM_STAGES - 1);
  localparam int BUB_MAX = (1 << BUB_W) - 1;

  // Request codes
  typedef enum logic [1:0] {
    REQ_CLOCK = 2'd0,
    REQ_SRC   = 2'd1,
    REQ_DST   = 2'd2,
    REQ_FLUSH = 2'd3
  } req_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOOP,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic capture;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic loop_done;
  } sts_t;

endpackage

FILE: hw/rtl/prhst_ctrl.sv
// Controller state machine: sequences request decode, shift loop and result.
module prhst_ctrl
  import prhst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_LOOP;
      ST_LOOP: begin
        if (sts.loop_done) state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_LOOP: cmd.step = !sts.loop_done;
      ST_DONE: cmd.capture = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

FILE: hw/rtl/prhst_dp.sv
// Datapath: pipeline slots, scan, shift logic, counters and result registers.
module prhst_dp
  import prhst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [1:0]       in_req_type,
  input  logic [REG_W-1:0] in_reg_num,
  input  logic [SEL_W-1:0] in_stage_sel,
  input  logic [SEL_W-1:0] in_flush_slots,
  input  logic [SEL_W-1:0] in_query_stage,
  output logic             out_valid,
  output logic [BUB_W-1:0] out_bubbles_inserted,
  output logic             out_hazard_found,
  output logic [CTR_W-1:0] out_cycle_total,
  output logic [CTR_W-1:0] out_flush_total,
  output logic [CTR_W-1:0] out_bubble_total,
  output logic [CTR_W-1:0] out_hazard_count
);

  // Latched request
  req_t             req_r, req_nxt;
  logic [REG_W-1:0] reg_r, reg_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic [SEL_W-1:0] slots_r, slots_nxt;
  logic [SEL_W-1:0] query_r, query_nxt;

  // Pipeline slots
  logic             valid_r [NUM_STAGES];
  logic             valid_nxt [NUM_STAGES];
  logic [REG_W-1:0] tag_r [NUM_STAGES];
  logic [REG_W-1:0] tag_nxt [NUM_STAGES];
  logic [SEL_W-1:0] rdy_r [NUM_STAGES];
  logic [SEL_W-1:0] rdy_nxt [NUM_STAGES];

  // Counters
  logic [CTR_W-1:0] haz_r [NUM_STAGES];
  logic [CTR_W-1:0] haz_nxt [NUM_STAGES];
  logic [CTR_W-1:0] cycle_r, cycle_nxt;
  logic [CTR_W-1:0] flush_r, flush_nxt;
  logic [CTR_W-1:0] bubble_r, bubble_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  logic [BUB_W-1:0] ins_r, ins_nxt;

  // Result registers
  logic             ovalid_r;
  logic [CTR_W-1:0] ohaz_r, ohaz_nxt;
  logic [BUB_W-1:0] oins_r;
  logic             ofound_r;
  logic [CTR_W-1:0] ocycle_r, oflush_r, obubble_r;

  // Shift control
  logic             shift_en;
  logic [SEL_W-1:0] shift_from;
  logic             hit;
  int               need;

  assign sts.loop_done = (cnt_r == '0);

  // Next-state logic for slots and counters
  always_comb begin
    req_nxt    = req_r;
    reg_nxt    = reg_r;
    sel_nxt    = sel_r;
    slots_nxt  = slots_r;
    query_nxt  = query_r;
    valid_nxt  = valid_r;
    tag_nxt    = tag_r;
    rdy_nxt    = rdy_r;
    haz_nxt    = haz_r;
    cycle_nxt  = cycle_r;
    flush_nxt  = flush_r;
    bubble_nxt = bubble_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    ins_nxt    = ins_r;
    shift_en   = 1'b0;
    shift_from = '0;
    hit        = 1'b0;
    need       = 0;

    if (cmd.load) begin
      req_nxt   = req_t'(in_req_type);
      reg_nxt   = in_reg_num;
      sel_nxt   = in_stage_sel;
      slots_nxt = in_flush_slots;
      query_nxt = in_query_stage;
      found_nxt = 1'b0;
      ins_nxt   = '0;
      cnt_nxt   = '0;
    end

    // First step of the request
    if (cmd.exec) begin
      unique case (req_r)
        REQ_CLOCK: begin
          cycle_nxt  = cycle_r + 1'b1;
          shift_en   = (int'(sel_r) < NUM_STAGES);
          shift_from = sel_r;
        end
        REQ_SRC: begin
          // youngest matching slot from first execute to before writeback
          for (int j = FIRST_EXEC_STAGE; j < NUM_STAGES - 1; j++) begin
            if (!hit && valid_r[j] && tag_r[j] == reg_r) begin
              hit        = 1'b1;
              haz_nxt[j] = haz_r[j] + 1'b1;
              found_nxt  = 1'b1;
              need = (int'(rdy_r[j]) - j) - (int'(sel_r) - DECODE_STAGE);
              if (need > 0) begin
                cnt_nxt = CNT_W'(need);
                ins_nxt = (need > BUB_MAX) ? BUB_W'(BUB_MAX) : BUB_W'(need);
              end
            end
          end
        end
        REQ_DST: begin
          valid_nxt[DECODE_STAGE] = 1'b1;
          tag_nxt[DECODE_STAGE]   = reg_r;
          rdy_nxt[DECODE_STAGE]   = sel_r;
        end
        REQ_FLUSH: cnt_nxt = CNT_W'(slots_r);
        default: cnt_nxt = '0;
      endcase
    end

    // One bubble or one flushed slot per cycle
    if (cmd.step) begin
      cnt_nxt   = cnt_r - 1'b1;
      cycle_nxt = cycle_r + 1'b1;
      shift_en  = 1'b1;
      if (req_r == REQ_FLUSH) begin
        flush_nxt  = flush_r + 1'b1;
        shift_from = '0;
      end else begin
        bubble_nxt = bubble_r + 1'b1;
        shift_from = SEL_W'(FIRST_EXEC_STAGE);
      end
    end

    // Shift slots above the freeze stage and empty the freeze slot
    if (shift_en) begin
      for (int j = NUM_STAGES - 1; j > 0; j--) begin
        if (j > int'(shift_from)) begin
          valid_nxt[j] = valid_r[j-1];
          tag_nxt[j]   = tag_r[j-1];
          rdy_nxt[j]   = rdy_r[j-1];
        end
      end
      for (int j = 0; j < NUM_STAGES; j++) begin
        if (j == int'(shift_from)) begin
          valid_nxt[j] = 1'b0;
          tag_nxt[j]   = '0;
          rdy_nxt[j]   = '0;
        end
      end
    end
  end

  // Hazard counter of the query stage
  always_comb begin
    ohaz_nxt = '0;
    for (int j = 0; j < NUM_STAGES; j++) begin
      if (int'(query_r) == j) ohaz_nxt = haz_r[j];
    end
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_STAGES; j++) begin
        valid_r[j] <= 1'b0;
        tag_r[j]   <= '0;
        rdy_r[j]   <= '0;
        haz_r[j]   <= '0;
      end
      cycle_r  <= CYCLE_RESET;
      flush_r  <= '0;
      bubble_r <= '0;
      cnt_r    <= '0;
      found_r  <= 1'b0;
      ins_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      tag_r    <= tag_nxt;
      rdy_r    <= rdy_nxt;
      haz_r    <= haz_nxt;
      cycle_r  <= cycle_nxt;
      flush_r  <= flush_nxt;
      bubble_r <= bubble_nxt;
      cnt_r    <= cnt_nxt;
      found_r  <= found_nxt;
      ins_r    <= ins_nxt;
      ovalid_r <= cmd.capture;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    reg_r   <= reg_nxt;
    sel_r   <= sel_nxt;
    slots_r <= slots_nxt;
    query_r <= query_nxt;
    if (cmd.capture) begin
      oins_r    <= ins_r;
      ofound_r  <= found_r;
      ocycle_r  <= cycle_r;
      oflush_r  <= flush_r;
      obubble_r <= bubble_r;
      ohaz_r    <= ohaz_nxt;
    end
  end

  assign out_valid            = ovalid_r;
  assign out_bubbles_inserted = oins_r;
  assign out_hazard_found     = ofound_r;
  assign out_cycle_total      = ocycle_r;
  assign out_flush_total      = oflush_r;
  assign out_bubble_total     = obubble_r;
  assign out_hazard_count     = ohaz_r;

  // Each loop step consumes one count and advances the cycle counter by one
  a_step_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("loop count did not decrement on step");

  a_step_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> cycle_r == $past(cycle_r) + 1'b1)
    else $error("cycle counter did not advance on step");

  a_no_step_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> cnt_r != '0)
    else $error("shift step with empty loop count");

  a_bubble_src: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.capture && ins_r != '0) |-> (found_r && req_r == REQ_SRC))
    else $error("bubbles reported without a source hazard");

endmodule

FILE: hw/rtl/pipeline_raw_hazard_stall_tracker.sv
// Top level of the RAW hazard stall tracker: controller plus datapath.
//
// Usage: a request item is taken at a rising edge where start is high and
// busy is low. in_req_type selects clock advance, source read, destination
// write or flush; in_reg_num, in_stage_sel, in_flush_slots and
// in_query_stage qualify it. Exactly one result item follows each request:
// out_valid is high for one cycle with the bubble count, hazard flag, the
// running cycle, flush and bubble totals and the hazard count of the
// queried stage. The receiver cannot stall, so results are never held.
// The shift loop moves the pipe one slot per cycle, one bubble (source
// read, at most 6 here) or one flushed slot (flush, at most 7) per step;
// other requests have no loop steps. An item keeps busy high until its
// result is out: busy drops in the cycle the result appears and a new
// item may be taken then.
// Reset (synchronous, rst_n low) empties every slot, clears the hazard,
// flush and bubble counters and sets the cycle counter to the pipeline
// fill cost of NUM_STAGES - 1.
module pipeline_raw_hazard_stall_tracker
  import prhst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_req_type,
  input  logic [REG_W-1:0] in_reg_num,
  input  logic [SEL_W-1:0] in_stage_sel,
  input  logic [SEL_W-1:0] in_flush_slots,
  input  logic [SEL_W-1:0] in_query_stage,
  output logic             out_valid,
  output logic [BUB_W-1:0] out_bubbles_inserted,
  output logic             out_hazard_found,
  output logic [CTR_W-1:0] out_cycle_total,
  output logic [CTR_W-1:0] out_flush_total,
  output logic [CTR_W-1:0] out_bubble_total,
  output logic [CTR_W-1:0] out_hazard_count
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  prhst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Slots, counters and result registers
  prhst_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_req_type          (in_req_type),
    .in_reg_num           (in_reg_num),
    .in_stage_sel         (in_stage_sel),
    .in_flush_slots       (in_flush_slots),
    .in_query_stage       (in_query_stage),
    .out_valid            (out_valid),
    .out_bubbles_inserted (out_bubbles_inserted),
    .out_hazard_found     (out_hazard_found),
    .out_cycle_total      (out_cycle_total),
    .out_flush_total      (out_flush_total),
    .out_bubble_total     (out_bubble_total),
    .out_hazard_count     (out_hazard_count)
  );

  // A result only appears once the item's work is finished
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

endmodule
